[sv/tfop_pkg.sv]
`default_nettype none

package tfop_pkg;

    localparam int DEPTH_DEF = 16;

    typedef enum logic [1:0] {
        REQ_ENQ   = 2'd0,
        REQ_FETCH = 2'd1,
        REQ_PURGE = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_QUEUED = 3'd0,
        ST_FULL   = 3'd1,
        ST_FETCH  = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_PURGED = 3'd4,
        ST_NONE   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PURGE
    } state_t;

    // one transmit descriptor, owner id forced to zero when unowned
    typedef struct packed {
        logic [15:0] handle;
        logic [15:0] len;
        logic [15:0] offset;
        logic [31:0] ip;
        logic [15:0] port;
        logic        has_owner;
        logic [7:0]  owner_id;
    } entry_t;

    typedef struct packed {
        logic load;   // take the incoming descriptor
        logic shift;  // take the neighbor's descriptor
    } cell_ctrl_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] handle;
        logic [15:0] len;
        logic [15:0] offset;
        logic [15:0] send_bytes;
        logic [31:0] ip;
        logic [15:0] port;
        logic        has_owner;
        logic [7:0]  owner;
        logic [4:0]  occupancy;
        logic        not_empty;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

[sv/transmit_fifo_with_owner_purge.sv]
// channel | dir | tdata                                 | tuser      | tlast
// s_      | in  | handle,len,offset,ip,port,own,owner    | req_type   | -
// m_      | out | handle,len,off,send,ip,port,own,owner, | status     | last
//         |     | occupancy,not_empty                   |            |
//
// One request at a time: the block accepts a request, then executes it. A purge
// walks the cell row with one scan pointer, one cell per cycle unless a full output
// register holds the scan, one result per hit.
// Reset clears the count and the control state; the cells hold no reset.
// A full output register that is not taken holds the execute or scan step.
`default_nettype none

module transmit_fifo_with_owner_purge
    import tfop_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // [15:0] buf_handle, [31:16] pkt_len, [47:32] start_offset, [79:48] dest_ip,
    // [95:80] dest_port, [96] has_owner, [104:97] owner_id, [111:105] zero
    input  wire  [111:0] s_tdata,
    // [1:0] req_type
    input  wire  [1:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // [15:0] out_handle, [31:16] out_len, [47:32] out_offset, [63:48] send_bytes,
    // [95:64] out_ip, [111:96] out_port, [112] out_has_owner, [120:113] out_owner,
    // [125:121] occupancy, [126] not_empty, [127] zero
    output logic [127:0] m_tdata,
    // [2:0] status
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH);

    state_t        state_reg, state_next;
    req_t          req_reg, req_next;
    entry_t        ent_reg, ent_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    result_t       res_reg, res_next;
    logic          mvalid_reg, mvalid_next;

    entry_t        din;
    logic [8:0]    key;
    cell_ctrl_t    ctrl  [DEPTH];
    entry_t        cdata [DEPTH];
    entry_t        cnbr  [DEPTH];
    logic [DEPTH-1:0] cmatch;
    logic [DEPTH-1:0] hit;
    logic [DEPTH-1:0] hit_other;
    logic          any_hit;
    logic          others;
    logic          p_hit;
    entry_t        sel;
    entry_t        head;
    logic          out_free;
    logic          do_load;
    logic          do_fetch;
    logic          do_pshift;
    logic          emit;
    logic [CW-1:0] occ_val;
    result_t       res;

    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // request register
    always_comb begin
        req_next = req_reg;
        ent_next = ent_reg;
        if (s_tvalid && s_tready) begin
            req_next           = req_t'(s_tuser);
            ent_next.handle    = s_tdata[15:0];
            ent_next.len       = s_tdata[31:16];
            ent_next.offset    = s_tdata[47:32];
            ent_next.ip        = s_tdata[79:48];
            ent_next.port      = s_tdata[95:80];
            ent_next.has_owner = s_tdata[96];
            ent_next.owner_id  = s_tdata[104:97];
        end
    end

    always_comb begin
        din          = ent_reg;
        din.owner_id = ent_reg.has_owner ? ent_reg.owner_id : 8'd0;
    end

    assign key = {ent_reg.has_owner, ent_reg.owner_id};

    // cell row; cell 0 is the head
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == DEPTH - 1) begin : g_end
                assign cnbr[gi] = '0;
            end else begin : g_mid
                assign cnbr[gi] = cdata[gi+1];
            end

            assign ctrl[gi].load  = do_load && (count_reg == CW'(gi));
            assign ctrl[gi].shift = do_fetch || (do_pshift && (PW'(gi) >= ptr_reg));

            // an unowned key names no peer
            assign hit[gi]       = cmatch[gi] && key[8] && (CW'(gi) < count_reg);
            assign hit_other[gi] = hit[gi] && (PW'(gi) != ptr_reg);

            tfop_cell u_cell (
                .aclk  (aclk),
                .ctrl  (ctrl[gi]),
                .din   (din),
                .nbr   (cnbr[gi]),
                .key   (key),
                .data  (cdata[gi]),
                .match (cmatch[gi])
            );
        end
    endgenerate

    assign any_hit = |hit;
    assign others  = |hit_other;
    assign p_hit   = hit[ptr_reg];
    assign sel     = cdata[ptr_reg];
    assign head    = cdata[0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (req_reg == REQ_NOP) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    state_next = (req_reg == REQ_PURGE && any_hit) ? S_PURGE : S_IDLE;
                end
            end
            S_PURGE: begin
                if (CW'(ptr_reg) >= count_reg) begin
                    state_next = S_IDLE;
                end else if (out_free && p_hit && !others) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath actions and results
    always_comb begin
        do_load    = 1'b0;
        do_fetch   = 1'b0;
        do_pshift  = 1'b0;
        emit       = 1'b0;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        occ_val    = count_reg;
        res        = '0;
        case (state_reg)
            S_EXEC: begin
                case (req_reg)
                    REQ_ENQ: begin
                        if (out_free) begin
                            emit     = 1'b1;
                            res.last = 1'b1;
                            if (count_reg == CW'(DEPTH)) begin
                                res.status = ST_FULL;
                            end else begin
                                do_load    = 1'b1;
                                count_next = count_reg + 1'b1;
                                occ_val    = count_next;
                                res.status = ST_QUEUED;
                            end
                        end
                    end
                    REQ_FETCH: begin
                        if (out_free) begin
                            emit     = 1'b1;
                            res.last = 1'b1;
                            if (count_reg == '0) begin
                                res.status = ST_EMPTY;
                            end else begin
                                do_fetch       = 1'b1;
                                count_next     = count_reg - 1'b1;
                                occ_val        = count_next;
                                res.status     = ST_FETCH;
                                res.handle     = head.handle;
                                res.len        = head.len;
                                res.offset     = head.offset;
                                res.send_bytes = (head.len > head.offset) ?
                                                 (head.len - head.offset) : 16'd0;
                                res.ip         = head.ip;
                                res.port       = head.port;
                                res.has_owner  = head.has_owner;
                                res.owner      = head.owner_id;
                            end
                        end
                    end
                    REQ_PURGE: begin
                        if (out_free) begin
                            ptr_next = '0;
                            if (!any_hit) begin
                                emit       = 1'b1;
                                res.last   = 1'b1;
                                res.status = ST_NONE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_PURGE: begin
                if (out_free && (CW'(ptr_reg) < count_reg)) begin
                    if (p_hit) begin
                        // drop this cell, later cells move down, pointer stays
                        emit       = 1'b1;
                        do_pshift  = 1'b1;
                        count_next = count_reg - 1'b1;
                        occ_val    = count_next;
                        res.status = ST_PURGED;
                        res.handle = sel.handle;
                        res.last   = !others;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.occupancy = 5'(occ_val);
        res.not_empty = (occ_val != '0);
    end

    // output register
    always_comb begin
        res_next    = res_reg;
        mvalid_next = mvalid_reg;
        if (emit) begin
            res_next    = res;
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ptr_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        ent_reg <= ent_next;
        res_reg <= res_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {1'b0, res_reg.not_empty, res_reg.occupancy, res_reg.owner,
                       res_reg.has_owner, res_reg.port, res_reg.ip, res_reg.send_bytes,
                       res_reg.offset, res_reg.len, res_reg.handle};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_PURGE |-> CW'(ptr_reg) < count_reg)
        else $error("purge scan pointer past occupied cells");

    a_mid_only_purge: assert property (@(posedge aclk) disable iff (!aresetn)
        mvalid_reg && !res_reg.last |-> res_reg.status == ST_PURGED)
        else $error("non-final result outside a purge");

    a_purge_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PURGE && out_free && p_hit) |=>
            count_reg == $past(count_reg) - 1'b1)
        else $error("purge hit did not remove an entry");

endmodule

`default_nettype wire

[sv/tfop_cell.sv]
`default_nettype none

module tfop_cell
    import tfop_pkg::*;
(
    input  wire        aclk,
    input  cell_ctrl_t ctrl,
    input  entry_t     din,
    input  entry_t     nbr,
    input  wire  [8:0] key,
    output entry_t     data,
    output logic       match
);

    entry_t data_reg;
    entry_t data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.load) begin
            data_next = din;
        end else if (ctrl.shift) begin
            data_next = nbr;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = ({data_reg.has_owner, data_reg.owner_id} == key);

endmodule

`default_nettype wire

[tb/sv/tb_transmit_fifo_with_owner_purge.sv]
`timescale 1ns / 1ps

module tb_transmit_fifo_with_owner_purge;
    import tfop_pkg::*;

    localparam int DEPTH     = DEPTH_DEF;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE    = 2 * DEPTH + 8;   // purge walk plus output slack

    typedef struct {
        req_t   req;
        entry_t desc;
    } tx_req_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    tx_req_t  tx_requests[$];   // requests not yet offered
    tx_req_t  on_bus;           // request currently offered on s_
    entry_t   shadow_fifo[$];   // descriptors the block should hold
    result_t  due_results[$];   // results still owed by the block

    int mismatches  = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_reqs    = 0;
    int holds_taken  = 0;
    int stall_left   = 0;

    logic [7:0] peers[4] = '{8'h00, 8'h5A, 8'hA5, 8'hFF};

    transmit_fifo_with_owner_purge u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // apply one accepted request to the shadow queue, queue up its results
    task automatic run_shadow_fifo(tx_req_t r);
        result_t res;
        result_t held;
        entry_t  e;
        int      i;
        int      hits;
        res  = '0;
        held = '0;
        hits = 0;
        case (r.req)
            REQ_ENQ: begin
                if (shadow_fifo.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    e = r.desc;
                    if (!e.has_owner)
                        e.owner_id = '0;
                    shadow_fifo.push_back(e);
                    res.status = ST_QUEUED;
                end
            end
            REQ_FETCH: begin
                if (shadow_fifo.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    e = shadow_fifo.pop_front();
                    res.status     = ST_FETCH;
                    res.handle     = e.handle;
                    res.len        = e.len;
                    res.offset     = e.offset;
                    res.send_bytes = (e.len > e.offset) ? e.len - e.offset : 16'd0;
                    res.ip         = e.ip;
                    res.port       = e.port;
                    res.has_owner  = e.has_owner;
                    res.owner      = e.owner_id;
                end
            end
            REQ_PURGE: begin
                i = 0;
                // unowned purge names no peer
                while (r.desc.has_owner && i < shadow_fifo.size()) begin
                    if (shadow_fifo[i].has_owner &&
                        shadow_fifo[i].owner_id == r.desc.owner_id) begin
                        if (hits != 0)
                            due_results.push_back(held);
                        held = '0;
                        held.status    = ST_PURGED;
                        held.handle    = shadow_fifo[i].handle;
                        shadow_fifo.delete(i);
                        held.occupancy = 5'(shadow_fifo.size());
                        held.not_empty = (shadow_fifo.size() != 0);
                        hits++;
                    end else begin
                        i++;
                    end
                end
                if (hits != 0) begin
                    held.last = 1'b1;
                    due_results.push_back(held);
                    return;
                end
                res.status = ST_NONE;
            end
            default: return;
        endcase
        res.occupancy = 5'(shadow_fifo.size());
        res.not_empty = (shadow_fifo.size() != 0);
        res.last      = 1'b1;
        due_results.push_back(res);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic entry_t desc(logic [15:0] h, logic [15:0] len, logic [15:0] off,
                                    logic [31:0] ip, logic [15:0] port, logic own,
                                    logic [7:0] id);
        entry_t d;
        d.handle    = h;
        d.len       = len;
        d.offset    = off;
        d.ip        = ip;
        d.port      = port;
        d.has_owner = own;
        d.owner_id  = id;
        return d;
    endfunction

    function automatic logic [7:0] pick_peer();
        if ($urandom_range(9) == 0)
            return 8'($urandom);
        return peers[2'($urandom_range(3))];
    endfunction

    function automatic entry_t random_desc();
        entry_t d;
        d = desc(16'($urandom), 16'($urandom), 16'd0, $urandom, 16'($urandom),
                 ($urandom_range(3) != 0), pick_peer());
        case ($urandom_range(3))
            0: d.offset = 16'($urandom);
            1: d.offset = d.len;
            default: d.offset = 16'($urandom_range(d.len));
        endcase
        return d;
    endfunction

    task automatic push_req(req_t r, entry_t d);
        tx_req_t t;
        t.req  = r;
        t.desc = d;
        tx_requests.push_back(t);
    endtask

    // mixes fill-heavy and drain-heavy stretches so both full and empty get hit
    task automatic queue_random_traffic(int n);
        int   done;
        int   roll;
        bit   fill_bias;
        req_t r;
        done      = 0;
        fill_bias = 1'b1;
        while (done < n) begin
            if (done % 16 == 0)
                fill_bias = 1'($urandom_range(1));
            roll = $urandom_range(99);
            if (roll < 4)
                r = REQ_NOP;
            else if (roll < 16)
                r = REQ_PURGE;
            else if (roll < (fill_bias ? 75 : 40))
                r = REQ_ENQ;
            else
                r = REQ_FETCH;
            push_req(r, random_desc());
            if (r != REQ_NOP)
                done++;
        end
    endtask

    task automatic wait_idle();
        while (tx_requests.size() != 0 || s_tvalid || due_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                run_shadow_fifo(on_bus);
            if (!s_tvalid || s_tready) begin
                if (tx_requests.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    on_bus = tx_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= on_bus.req;
                    s_tdata  <= {7'd0, on_bus.desc.owner_id, on_bus.desc.has_owner,
                                 on_bus.desc.port, on_bus.desc.ip, on_bus.desc.offset,
                                 on_bus.desc.len, on_bus.desc.handle};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver backpressure, with an optional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (holds_taken != hold_reqs) begin
            holds_taken <= hold_reqs;
            stall_left  <= LONG_HOLD;
            m_tready    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result: status %0d handle 0x%0h", m_tuser, m_tdata[15:0]);
                mismatches++;
            end else begin
                check_field("status",        32'(due_results[0].status),     32'(m_tuser));
                check_field("out_handle",    32'(due_results[0].handle),
                            32'(m_tdata[15:0]));
                check_field("out_len",       32'(due_results[0].len),
                            32'(m_tdata[31:16]));
                check_field("out_offset",    32'(due_results[0].offset),
                            32'(m_tdata[47:32]));
                check_field("send_bytes",    32'(due_results[0].send_bytes),
                            32'(m_tdata[63:48]));
                check_field("out_ip",        due_results[0].ip,         m_tdata[95:64]);
                check_field("out_port",      32'(due_results[0].port),
                            32'(m_tdata[111:96]));
                check_field("out_has_owner", 32'(due_results[0].has_owner),
                            32'(m_tdata[112]));
                check_field("out_owner",     32'(due_results[0].owner),
                            32'(m_tdata[120:113]));
                check_field("occupancy",     32'(due_results[0].occupancy),
                            32'(m_tdata[125:121]));
                check_field("not_empty",     32'(due_results[0].not_empty),
                            32'(m_tdata[126]));
                check_field("last",          32'(due_results[0].last),       32'(m_tlast));
                void'(due_results.pop_front());
            end
        end
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        src_idle_pct = 31;
        snk_idle_pct = 77;

        // corner requests on an empty queue
        push_req(REQ_FETCH, desc(16'h0, 16'h0, 16'h0, 32'h0, 16'h0, 1'b0, 8'h00));
        push_req(REQ_PURGE, desc(16'h0, 16'h0, 16'h0, 32'h0, 16'h0, 1'b1, 8'h5A));
        push_req(REQ_NOP,   desc(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                                 1'b1, 8'hFF));
        // field extremes, zero send length and offset past the length
        push_req(REQ_ENQ, desc(16'h0, 16'h0, 16'h0, 32'h0, 16'h0, 1'b0, 8'hFF));
        push_req(REQ_ENQ, desc(16'hFFFF, 16'hFFFF, 16'h0, 32'hFFFF_FFFF, 16'hFFFF,
                               1'b1, 8'hFF));
        push_req(REQ_ENQ, desc(16'h1234, 16'd100, 16'd100, 32'hC0A8_0001, 16'd53,
                               1'b1, 8'h5A));
        push_req(REQ_ENQ, desc(16'hBEEF, 16'd10, 16'd200, 32'h0A00_0002, 16'd4500,
                               1'b1, 8'hFF));
        for (int k = 0; k < 12; k++)
            push_req(REQ_ENQ, desc(16'(16'h100 + k), 16'(1500 - k), 16'(k), $urandom,
                                   16'(1024 + k), (k % 3 != 2), (k % 3 == 0) ? 8'h5A : 8'hA5));
        // queue is full now
        push_req(REQ_ENQ, desc(16'hDEAD, 16'd64, 16'd0, 32'h7F00_0001, 16'd80, 1'b1, 8'h01));
        push_req(REQ_PURGE, desc(16'h0, 16'h0, 16'h0, 32'h0, 16'h0, 1'b0, 8'h00));
        push_req(REQ_PURGE, desc(16'h0, 16'h0, 16'h0, 32'h0, 16'h0, 1'b1, 8'h5A));
        push_req(REQ_FETCH, desc(16'h0, 16'h0, 16'h0, 32'h0, 16'h0, 1'b0, 8'h00));
        push_req(REQ_FETCH, desc(16'h0, 16'h0, 16'h0, 32'h0, 16'h0, 1'b0, 8'h00));
        push_req(REQ_PURGE, desc(16'h0, 16'h0, 16'h0, 32'h0, 16'h0, 1'b1, 8'hFF));
        queue_random_traffic(50);
        wait_idle();

        src_idle_pct = 77;
        snk_idle_pct = 31;
        queue_random_traffic(50);
        wait_idle();

        // no idling; receiver blocks for a long stretch while requests keep coming
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_reqs++;
        queue_random_traffic(50);
        wait_idle();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[transmit_fifo_with_owner_purge.f]
sv/tfop_pkg.sv
sv/tfop_cell.sv
sv/transmit_fifo_with_owner_purge.sv
tb/sv/tb_transmit_fifo_with_owner_purge.sv
